FILE: rtl/sac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sac_pkg
// Shared widths, time constants and types for the swept box collision block.
// ----------------------------------------------------------------------------
package sac_pkg;

    // Coordinate field width; the fraction bits cancel in every division.
    localparam int CW = 24;
    // Fraction bits of a time value.
    localparam int TF = 16;
    // Quotient bits produced by the divider; anything wider saturates.
    localparam int QB = TF + 2;
    // Signed width of a saturated time, including the unbounded codes.
    localparam int TW = TF + 3;
    // Width of the reported entry time.
    localparam int ETW = TF + 1;
    // Divider lane latency: magnitude stage, one stage per bit, result stage.
    localparam int DIV_LAT = QB + 2;
    // Edges from the one that takes a word to the one that takes its result.
    localparam int LATENCY = DIV_LAT + 2;

    localparam logic signed [TW-1:0] T_ONE     = TW'(1) <<< TF;
    localparam logic signed [TW-1:0] T_SAT     = TW'(2) <<< TF;
    localparam logic signed [TW-1:0] T_NEG_UNB = -T_SAT - TW'(1);
    localparam logic signed [TW-1:0] T_POS_UNB = T_SAT + TW'(1);

    localparam logic signed [1:0] NRM_ZERO = 2'sb00;
    localparam logic signed [1:0] NRM_POS  = 2'sb01;
    localparam logic signed [1:0] NRM_NEG  = 2'sb11;

    // Per-query flags that travel beside the divider lanes.
    typedef struct packed {
        logic miss;
        logic dx_zero;
        logic dy_zero;
        logic dx_pos;
        logic dy_pos;
    } t_side;

endpackage
`default_nettype wire

FILE: rtl/swept_aabb_collision.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: a query word passes an input register, four divider lanes (entry stage, 18 quotient
// bit stages, result stage) and the output register before o_valid marks its result.
// Throughput: one query per cycle; busy is never raised.
// Reset clears only the valid chain; no result appears for queries lost in reset.
// ----------------------------------------------------------------------------
// swept_aabb_collision
// Swept axis-aligned box test giving entry time and contact normal per query.
// ----------------------------------------------------------------------------
module swept_aabb_collision
    import sac_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic signed [CW-1:0]  i_mover_left,
    input  wire logic signed [CW-1:0]  i_mover_top,
    input  wire logic signed [CW-1:0]  i_mover_right,
    input  wire logic signed [CW-1:0]  i_mover_bottom,
    input  wire logic signed [CW-1:0]  i_move_x,
    input  wire logic signed [CW-1:0]  i_move_y,
    input  wire logic signed [CW-1:0]  i_fixed_left,
    input  wire logic signed [CW-1:0]  i_fixed_top,
    input  wire logic signed [CW-1:0]  i_fixed_right,
    input  wire logic signed [CW-1:0]  i_fixed_bottom,
    output logic                       o_valid,
    output logic                       o_hit,
    output logic [ETW-1:0]             o_entry_time,
    output logic signed [1:0]          o_normal_x,
    output logic signed [1:0]          o_normal_y
);

    assign busy = 1'b0;

    // Input stage.
    logic                 r_in_vld;
    logic signed [CW-1:0] r_ml, r_mt, r_mr, r_mb, r_dx, r_dy, r_sl, r_st, r_sr, r_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ml <= i_mover_left;
        r_mt <= i_mover_top;
        r_mr <= i_mover_right;
        r_mb <= i_mover_bottom;
        r_dx <= i_move_x;
        r_dy <= i_move_y;
        r_sl <= i_fixed_left;
        r_st <= i_fixed_top;
        r_sr <= i_fixed_right;
        r_sb <= i_fixed_bottom;
    end

    // Broad phase and divider operands.
    logic signed [CW:0] w_bl, w_bt, w_br, w_bb;
    logic signed [CW:0] w_xen_n, w_xex_n, w_yen_n, w_yex_n;
    t_side              w_side;

    always_comb begin
        w_side.dx_pos  = r_dx > 0;
        w_side.dy_pos  = r_dy > 0;
        w_side.dx_zero = r_dx == '0;
        w_side.dy_zero = r_dy == '0;
        w_bl = w_side.dx_pos ? CW'(0) + r_ml : r_ml + r_dx;
        w_br = w_side.dx_pos ? r_mr + r_dx : CW'(0) + r_mr;
        w_bt = w_side.dy_pos ? CW'(0) + r_mt : r_mt + r_dy;
        w_bb = w_side.dy_pos ? r_mb + r_dy : CW'(0) + r_mb;
        w_side.miss = (w_br < r_sl) || (w_bl > r_sr) || (w_bb < r_st) || (w_bt > r_sb)
                      || (w_side.dx_zero && w_side.dy_zero);
        w_xen_n = w_side.dx_pos ? (r_sl - r_mr) : (r_sr - r_ml);
        w_xex_n = w_side.dx_pos ? (r_sr - r_ml) : (r_sl - r_mr);
        w_yen_n = w_side.dy_pos ? (r_st - r_mb) : (r_sb - r_mt);
        w_yex_n = w_side.dy_pos ? (r_sb - r_mt) : (r_st - r_mb);
    end

    logic signed [TW-1:0] w_xen_q, w_xex_q, w_yen_q, w_yex_q;

    sac_div u_div_xen (.i_clk(i_clk), .i_num(w_xen_n), .i_den(r_dx), .o_quo(w_xen_q));
    sac_div u_div_xex (.i_clk(i_clk), .i_num(w_xex_n), .i_den(r_dx), .o_quo(w_xex_q));
    sac_div u_div_yen (.i_clk(i_clk), .i_num(w_yen_n), .i_den(r_dy), .o_quo(w_yen_q));
    sac_div u_div_yex (.i_clk(i_clk), .i_num(w_yex_n), .i_den(r_dy), .o_quo(w_yex_q));

    // Flags and valid bits ride beside the divider lanes.
    t_side r_side [0:DIV_LAT-1];
    logic  r_vld  [0:DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_vld[0] <= r_in_vld;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= w_side;
        for (int i = 1; i < DIV_LAT; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    // Interval merge and normal choice.
    t_side                w_s;
    logic signed [TW-1:0] w_xen, w_xex, w_yen, w_yex, w_ten, w_tex;
    logic                 w_hit;

    always_comb begin
        w_s   = r_side[DIV_LAT-1];
        // A still axis never limits the interval.
        w_xen = w_s.dx_zero ? T_NEG_UNB : w_xen_q;
        w_xex = w_s.dx_zero ? T_POS_UNB : w_xex_q;
        w_yen = w_s.dy_zero ? T_NEG_UNB : w_yen_q;
        w_yex = w_s.dy_zero ? T_POS_UNB : w_yex_q;
        w_ten = (w_xen > w_yen) ? w_xen : w_yen;
        w_tex = (w_xex < w_yex) ? w_xex : w_yex;
        w_hit = !w_s.miss
                && !((w_xen < 0) && (w_yen < 0))
                && !(w_xen > T_ONE) && !(w_yen > T_ONE)
                && !(w_ten > w_tex);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_vld[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        o_hit        <= w_hit;
        o_entry_time <= w_hit ? w_ten[ETW-1:0] : '0;
        o_normal_x   <= NRM_ZERO;
        o_normal_y   <= NRM_ZERO;
        if (w_hit) begin
            if (w_xen > w_yen) begin
                o_normal_x <= w_s.dx_pos ? NRM_NEG : NRM_POS;
            end else begin
                o_normal_y <= w_s.dy_pos ? NRM_NEG : NRM_POS;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/sac_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sac_div
// Pipelined floor division (num << TF) / den, saturated to +-2.0, one
// quotient bit per stage.
// ----------------------------------------------------------------------------
module sac_div
    import sac_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic signed [CW:0]   i_num,
    input  wire logic signed [CW-1:0] i_den,
    output logic signed [TW-1:0]      o_quo
);

    logic [CW:0]   w_an;
    logic [CW-1:0] w_ad;
    logic          w_ovf;

    logic [CW-1:0] r_rem [0:QB];
    logic [CW-1:0] r_den [0:QB];
    logic [QB-1:0] r_q   [0:QB];
    logic [1:0]    r_lo  [0:QB];
    logic          r_neg [0:QB];
    logic          r_ovf [0:QB];

    always_comb begin
        w_an  = i_num[CW] ? (~i_num + 1'b1) : i_num;
        w_ad  = i_den[CW-1] ? (~i_den + 1'b1) : i_den;
        // A quotient of 4.0 or more saturates, so the remaining bits fit QB.
        w_ovf = {2'b00, w_an[CW-1:0]} >= {w_ad, 2'b00};
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= {2'b00, w_an[CW-1:2]};
        r_lo[0]  <= w_an[1:0];
        r_den[0] <= w_ad;
        r_q[0]   <= '0;
        r_neg[0] <= i_num[CW] ^ i_den[CW-1];
        r_ovf[0] <= w_ovf;
    end

    for (genvar k = 1; k <= QB; k++) begin : g_stage
        logic          w_bit;
        logic [CW:0]   w_t;
        logic [CW:0]   w_d;
        logic          w_ge;

        if (k == 1) begin : g_b1
            assign w_bit = r_lo[k-1][1];
        end else if (k == 2) begin : g_b0
            assign w_bit = r_lo[k-1][0];
        end else begin : g_bz
            assign w_bit = 1'b0;
        end

        always_comb begin
            w_t  = {r_rem[k-1], w_bit};
            w_d  = w_t - {1'b0, r_den[k-1]};
            w_ge = w_t >= {1'b0, r_den[k-1]};
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= w_ge ? w_d[CW-1:0] : w_t[CW-1:0];
            r_q[k]   <= {r_q[k-1][QB-2:0], w_ge};
            r_lo[k]  <= r_lo[k-1];
            r_den[k] <= r_den[k-1];
            r_neg[k] <= r_neg[k-1];
            r_ovf[k] <= r_ovf[k-1];
        end
    end

    logic [TW-1:0] w_qm;
    logic [TW-1:0] w_mag;
    logic          w_sat;

    // A negative quotient rounds its magnitude up to give the floor.
    always_comb begin
        w_qm  = {1'b0, r_q[QB]} + TW'(r_neg[QB] && (r_rem[QB] != '0));
        w_sat = r_ovf[QB] || (w_qm > T_SAT);
        w_mag = w_sat ? T_SAT : w_qm;
    end

    always_ff @(posedge i_clk) begin
        o_quo <= r_neg[QB] ? -$signed(w_mag) : $signed(w_mag);
    end

endmodule
`default_nettype wire

FILE: rtl/sac_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sac_chk
// Port-level checks for the swept box collision block.
// ----------------------------------------------------------------------------
module sac_chk
    import sac_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              o_valid,
    input wire logic              o_hit,
    input wire logic [ETW-1:0]    o_entry_time,
    input wire logic signed [1:0] o_normal_x,
    input wire logic signed [1:0] o_normal_y
);

    // Every result word comes from a query taken a fixed time earlier.
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result word without a query");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    // A hit carries exactly one nonzero normal component and a time in range.
    a_hit_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (((o_normal_x != 2'sb00) ^ (o_normal_y != 2'sb00))
                                && (o_entry_time <= ETW'(T_ONE))))
        else $error("bad hit word");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> ((o_entry_time == '0) && (o_normal_x == 2'sb00)
                                 && (o_normal_y == 2'sb00)))
        else $error("miss word not cleared");

endmodule

bind swept_aabb_collision sac_chk u_sac_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_hit       (o_hit),
    .o_entry_time(o_entry_time),
    .o_normal_x  (o_normal_x),
    .o_normal_y  (o_normal_y)
);
`default_nettype wire

FILE: tb/sv/swept_aabb_collision_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept box collision testbench
// Drives box-pair queries through the start/busy handshake, predicts each
// hit, entry time and normal in a behavioral model and checks every strobed
// result against the oldest prediction.
// ----------------------------------------------------------------------------
module swept_aabb_collision_test;
    import sac_pkg::*;

    typedef struct packed {
        logic signed [CW-1:0] ml, mt, mr, mb, dx, dy, sl, st, sr, sb;
    } t_query;

    typedef struct packed {
        logic                 hit;
        logic [ETW-1:0]       t;
        logic signed [1:0]    nx;
        logic signed [1:0]    ny;
    } t_contact;

    localparam longint ONE = longint'(1) << TF;
    localparam longint SAT = 2 * ONE;
    localparam int LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [CW-1:0] q_ml = '0, q_mt = '0, q_mr = '0, q_mb = '0, q_dx = '0;
    logic signed [CW-1:0] q_dy = '0, q_sl = '0, q_st = '0, q_sr = '0, q_sb = '0;
    logic o_valid, o_hit;
    logic [ETW-1:0] o_entry_time;
    logic signed [1:0] o_normal_x, o_normal_y;

    t_query   pending_queries[$];
    t_contact expected_contacts[$];
    int       errors = 0;
    int       cycles = 0;
    int       gap = 0;
    bit       stim_done = 1'b0;

    swept_aabb_collision i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mover_left(q_ml), .i_mover_top(q_mt), .i_mover_right(q_mr),
        .i_mover_bottom(q_mb), .i_move_x(q_dx), .i_move_y(q_dy),
        .i_fixed_left(q_sl), .i_fixed_top(q_st), .i_fixed_right(q_sr),
        .i_fixed_bottom(q_sb), .o_valid(o_valid), .o_hit(o_hit),
        .o_entry_time(o_entry_time), .o_normal_x(o_normal_x),
        .o_normal_y(o_normal_y)
    );

    always #5 i_clk = ~i_clk;

    // Floor division scaled to time fraction bits, saturated to +-2.0.
    function automatic longint axis_time(longint num, longint den);
        longint n, q, r;
        n = num * ONE;
        q = n / den;
        r = n % den;
        if (r != 0 && ((r < 0) != (den < 0))) q = q - 1;
        if (q > SAT) q = SAT;
        if (q < -SAT) q = -SAT;
        return q;
    endfunction

    function automatic t_contact sweep_contact(t_query q);
        t_contact c;
        longint ml, mt, mr, mb, dx, dy, sl, st, sr, sb;
        longint bl, bt, br, bb, xen, xex, yen, yex, ten, tex;
        ml = q.ml; mt = q.mt; mr = q.mr; mb = q.mb; dx = q.dx; dy = q.dy;
        sl = q.sl; st = q.st; sr = q.sr; sb = q.sb;
        c = '0;
        bl = dx > 0 ? ml : ml + dx;
        bt = dy > 0 ? mt : mt + dy;
        br = dx > 0 ? mr + dx : mr;
        bb = dy > 0 ? mb + dy : mb;
        if (br < sl || bl > sr || bb < st || bt > sb) return c;
        if (dx == 0 && dy == 0) return c;
        if (dx > 0) begin
            xen = axis_time(sl - mr, dx); xex = axis_time(sr - ml, dx);
        end else if (dx < 0) begin
            xen = axis_time(sr - ml, dx); xex = axis_time(sl - mr, dx);
        end else begin
            xen = -SAT - 1; xex = SAT + 1;
        end
        if (dy > 0) begin
            yen = axis_time(st - mb, dy); yex = axis_time(sb - mt, dy);
        end else if (dy < 0) begin
            yen = axis_time(sb - mt, dy); yex = axis_time(st - mb, dy);
        end else begin
            yen = -SAT - 1; yex = SAT + 1;
        end
        if ((xen < 0 && yen < 0) || xen > ONE || yen > ONE) return c;
        ten = xen > yen ? xen : yen;
        tex = xex < yex ? xex : yex;
        if (ten > tex) return c;
        c.hit = 1'b1;
        c.t = ETW'(ten);
        if (xen > yen) c.nx = dx > 0 ? NRM_NEG : NRM_POS;
        else c.ny = dy > 0 ? NRM_NEG : NRM_POS;
        return c;
    endfunction

    function automatic logic signed [CW-1:0] rnd_coord(int span);
        return CW'($urandom_range(2 * span) - span);
    endfunction

    // Mostly a mover placed near a fixed box with a random move; sometimes raw noise.
    function automatic t_query random_query();
        t_query q;
        int w, h, k, span;
        k = $urandom_range(9);
        if (k == 0) begin
            q.ml = CW'($urandom); q.mt = CW'($urandom); q.mr = CW'($urandom);
            q.mb = CW'($urandom); q.dx = CW'($urandom); q.dy = CW'($urandom);
            q.sl = CW'($urandom); q.st = CW'($urandom); q.sr = CW'($urandom);
            q.sb = CW'($urandom);
            return q;
        end
        span = k < 4 ? 64 : (k < 8 ? 4096 : 2000000);
        w = $urandom_range(span); h = $urandom_range(span);
        q.sl = rnd_coord(span); q.st = rnd_coord(span);
        q.sr = q.sl + CW'($urandom_range(span)); q.sb = q.st + CW'($urandom_range(span));
        q.ml = q.sl + rnd_coord(3 * span); q.mt = q.st + rnd_coord(3 * span);
        if ($urandom_range(3) == 0) begin
            q.ml = q.sr + CW'($urandom_range(3)); q.mt = q.st;
        end
        q.mr = q.ml + CW'(w); q.mb = q.mt + CW'(h);
        q.dx = $urandom_range(5) == 0 ? '0 : rnd_coord(4 * span);
        q.dy = $urandom_range(5) == 0 ? '0 : rnd_coord(4 * span);
        if ($urandom_range(7) == 0) begin
            q.dx = $urandom_range(1) ? CW'(-8388608) : CW'(8388607);
        end
        return q;
    endfunction

    function automatic int random_gap();
        if ($urandom_range(3) != 0) return 0;
        return $urandom_range(9) == 0 ? $urandom_range(40) : $urandom_range(3);
    endfunction

    // Driver: start stays high over back-to-back words.
    always @(posedge i_clk) begin
        t_query q;
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_contacts.insert(expected_contacts.size(), sweep_contact(
                    {q_ml, q_mt, q_mr, q_mb, q_dx, q_dy, q_sl, q_st, q_sr, q_sb}));
                gap <= random_gap();
            end
            if ((start && !busy) || !start) begin
                if (pending_queries.size() != 0 && (start ? random_gap() == 0 : gap == 0))
                begin
                    q = pending_queries.pop_front();
                    {q_ml, q_mt, q_mr, q_mb, q_dx, q_dy, q_sl, q_st, q_sr, q_sb} <= q;
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                    if (!start && gap > 0) gap <= gap - 1;
                end
            end
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        t_contact e;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) begin
            if (expected_contacts.size() == 0) begin
                $error("unexpected result word");
                errors++;
            end else begin
                e = expected_contacts.pop_front();
                if (o_hit !== e.hit) begin
                    $error("hit: expected %0d, got %0d", e.hit, o_hit); errors++;
                end
                if (o_entry_time !== e.t) begin
                    $error("entry_time: expected %0d, got %0d", e.t, o_entry_time);
                    errors++;
                end
                if (o_normal_x !== e.nx) begin
                    $error("normal_x: expected %0d, got %0d", e.nx, o_normal_x); errors++;
                end
                if (o_normal_y !== e.ny) begin
                    $error("normal_y: expected %0d, got %0d", e.ny, o_normal_y); errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic add_query(int ml, int mt, int mr, int mb, int dx, int dy,
                             int sl, int st, int sr, int sb);
        pending_queries.insert(pending_queries.size(),
                               {CW'(ml), CW'(mt), CW'(mr), CW'(mb), CW'(dx),
                                CW'(dy), CW'(sl), CW'(st), CW'(sr), CW'(sb)});
    endtask

    initial begin
        localparam int MX = 8388607;
        localparam int MN = -8388608;
        // Plain hits from each side, on each axis.
        add_query(0, 0, 256, 256, 1024, 0, 512, 0, 768, 256);
        add_query(1024, 0, 1280, 256, -1024, 0, 0, 0, 256, 256);
        add_query(0, 0, 256, 256, 0, 1024, 0, 512, 256, 768);
        add_query(0, 1024, 256, 1280, 0, -1024, 0, 0, 256, 256);
        // Diagonal with equal entry times selects the y normal.
        add_query(0, 0, 256, 256, 512, 512, 512, 512, 768, 768);
        // Zero displacement, overlapping boxes.
        add_query(0, 0, 256, 256, 0, 0, 100, 100, 300, 300);
        // Broad-phase miss and exact touch.
        add_query(0, 0, 256, 256, 100, 0, 512, 0, 768, 256);
        add_query(0, 0, 256, 256, 256, 0, 512, 0, 768, 256);
        // Already overlapping, moving away; touching at the start; reversed interval.
        add_query(0, 0, 256, 256, -100, 10, 100, 100, 300, 300);
        add_query(0, 0, 256, 256, 1, 0, 256, 0, 512, 256);
        add_query(0, 0, 256, 256, 1000, 1000, 900, -500, 1200, 100);
        // Field extremes.
        add_query(MN, MN, MX, MX, MX, MN, MN, MN, MX, MX);
        add_query(MN, MN, MN, MN, MX, MX, MX, MX, MX, MX);
        add_query(MX, MX, MX, MX, MN, MN, MN, MN, MN, MN);
        add_query(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1);
        add_query(0, 0, 0, 0, MN, 1, MN, 0, MN, 0);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (1350) pending_queries.insert(pending_queries.size(), random_query());
        wait (pending_queries.size() == 0 && !start);
        wait (expected_contacts.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
